// File: hdl/tsfla_pkg.sv
// Shared types and codes for the tagged slot allocator.
package tsfla_pkg;

  localparam int ACTION_W = 2;
  localparam int TAGS_W   = 16;
  localparam int INDEX_W  = 10;
  localparam int SLOT_W   = 10;
  localparam int RESUME_W = 11;
  localparam int STATUS_W = 3;

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SCAN  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_EXHAUSTED    = 3'd1,
    ST_ZERO_TAGS    = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_NO_MATCH     = 3'd4
  } status_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TAGS_W-1:0]   query_tags;
    logic [INDEX_W-1:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [RESUME_W-1:0] resume_index;
    status_t             status;
  } rsp_t;

endpackage

// File: hdl/tsfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsfla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/tsfla_cmp.sv
// Shared tag-containment compare and slot pointer increment unit.
module tsfla_cmp #(
  parameter int TAG_BITS = 16,
  parameter int IDX_W    = 10
) (
  input  logic [TAG_BITS-1:0] tags,
  input  logic [TAG_BITS-1:0] query,
  input  logic [IDX_W-1:0]    ptr,
  output logic                hit,
  output logic [IDX_W:0]      ptr_inc
);

  // Hit when every query bit is present in the stored tags.
  assign hit     = ((tags & query) == query);
  assign ptr_inc = {1'b0, ptr} + {{IDX_W{1'b0}}, 1'b1};

endmodule

// File: hdl/tagged_slot_free_list_allocator_top.sv
// Top level of the tagged slot allocator: sequencer, free list head and slot tables.
//
// Slot allocator over SLOT_COUNT slots, each holding a TAG_BITS tag mask. Free slots
// are chained in a singly linked list kept in a link RAM; the list head is a register.
// A request allocates (pops the head and stores a nonzero mask), frees (clears the
// tags and pushes the slot on the head), or scans from a start slot for the first slot
// whose tags hold every query bit. Every request gives exactly one response with a
// status code. After reset the block runs a clearing pass over all SLOT_COUNT slots that
// writes the tag RAM to zero and the link RAM to i+1; requests are stalled meanwhile.
// One request is worked at a time. Allocate steps through a head link read and a tag write,
// free through a tag read and a conditional write; refused requests and the unused action
// code go straight to the response. A scan examines one slot per cycle through the single
// tag RAM read port, checking each slot while reading the next, up to the end of the table.
// A finished response sits in an output register, so the next request is taken while
// the previous response waits.
module tagged_slot_free_list_allocator_top #(
  parameter int SLOT_COUNT = 1024,
  parameter int TAG_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  tsfla_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output tsfla_pkg::rsp_t   rsp
);

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int LINK_W = IDX_W + 1;

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_ALLOC_RD = 8'b0000_0100,
    S_ALLOC_WR = 8'b0000_1000,
    S_FREE_RD  = 8'b0001_0000,
    S_FREE_WR  = 8'b0010_0000,
    S_SCAN     = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state;

  // Free list head; SLOT_COUNT or more means the list is exhausted.
  logic [LINK_W-1:0]   free_head;
  logic [IDX_W-1:0]    clr_ptr;
  logic [IDX_W-1:0]    op_idx;
  logic [TAG_BITS-1:0] op_q;
  logic [LINK_W-1:0]   scan_ptr;
  logic [IDX_W-1:0]    chk_ptr;
  logic                chk_vld;
  logic [tsfla_pkg::SLOT_W-1:0]   res_slot;
  logic [tsfla_pkg::RESUME_W-1:0] res_resume;
  tsfla_pkg::status_t             res_status;

  // Request decode.
  logic [31:0]         idx_wide;
  logic                idx_ok;
  logic [TAG_BITS-1:0] req_q;
  logic                head_empty;
  logic                req_take;
  state_t                         state_next;
  logic [tsfla_pkg::SLOT_W-1:0]   res_slot_next;
  logic [tsfla_pkg::RESUME_W-1:0] res_resume_next;
  tsfla_pkg::status_t             res_status_next;

  // Memory ports.
  logic                tag_we;
  logic [IDX_W-1:0]    tag_waddr;
  logic [TAG_BITS-1:0] tag_wdata;
  logic [IDX_W-1:0]    tag_raddr;
  logic [TAG_BITS-1:0] tag_rdata;
  logic                link_we;
  logic [IDX_W-1:0]    link_waddr;
  logic [LINK_W-1:0]   link_wdata;
  logic [LINK_W-1:0]   link_rdata;

  // Shared unit.
  logic [IDX_W-1:0]    cmp_ptr;
  logic                cmp_hit;
  logic [LINK_W-1:0]   cmp_inc;
  logic                scan_end;

  assign idx_wide   = 32'(req.slot_index);
  assign idx_ok     = (idx_wide < 32'(SLOT_COUNT));
  assign req_q      = TAG_BITS'(req.query_tags);
  assign head_empty = (free_head >= LINK_W'(SLOT_COUNT));
  assign req_stall  = (state != S_IDLE);
  assign req_take   = req_valid && (state == S_IDLE);
  assign scan_end   = (scan_ptr >= LINK_W'(SLOT_COUNT));

  // Next state and preset response for a request taken in idle. Refused requests
  // and the unused action go straight to the response.
  always_comb begin
    state_next      = S_DONE;
    res_slot_next   = '0;
    res_resume_next = '0;
    res_status_next = tsfla_pkg::ST_OK;
    case (req.action)
      tsfla_pkg::ACT_ALLOC: begin
        if (head_empty) begin
          res_status_next = tsfla_pkg::ST_EXHAUSTED;
        end else if (req_q == '0) begin
          res_status_next = tsfla_pkg::ST_ZERO_TAGS;
        end else begin
          state_next = S_ALLOC_RD;
        end
      end
      tsfla_pkg::ACT_FREE: begin
        res_slot_next = req.slot_index;
        if (!idx_ok) begin
          res_status_next = tsfla_pkg::ST_ALREADY_FREE;
        end else begin
          state_next = S_FREE_RD;
        end
      end
      tsfla_pkg::ACT_SCAN: begin
        if (!idx_ok) begin
          res_resume_next = tsfla_pkg::RESUME_W'(SLOT_COUNT);
          res_status_next = tsfla_pkg::ST_NO_MATCH;
        end else begin
          state_next = S_SCAN;
        end
      end
      default: begin
      end
    endcase
  end

  // The increment serves the clearing pass (link value i+1) and the scan resume point.
  assign cmp_ptr = (state == S_CLEAR) ? clr_ptr : chk_ptr;

  tsfla_cmp #(
    .TAG_BITS (TAG_BITS),
    .IDX_W    (IDX_W)
  ) u_cmp (
    .tags    (tag_rdata),
    .query   (op_q),
    .ptr     (cmp_ptr),
    .hit     (cmp_hit),
    .ptr_inc (cmp_inc)
  );

  // Memory write and read address steering.
  always_comb begin
    tag_we     = 1'b0;
    tag_waddr  = op_idx;
    tag_wdata  = '0;
    link_we    = 1'b0;
    link_waddr = op_idx;
    link_wdata = free_head;
    tag_raddr  = (state == S_SCAN) ? scan_ptr[IDX_W-1:0] : op_idx;
    case (state)
      S_CLEAR: begin
        tag_we     = 1'b1;
        tag_waddr  = clr_ptr;
        link_we    = 1'b1;
        link_waddr = clr_ptr;
        link_wdata = cmp_inc;
      end
      S_ALLOC_WR: begin
        // Store the mask in the head slot.
        tag_we    = 1'b1;
        tag_waddr = free_head[IDX_W-1:0];
        tag_wdata = op_q;
      end
      S_FREE_WR: begin
        // If the slot holds tags, clear them and link the slot in front of the current head.
        tag_we  = (tag_rdata != '0);
        link_we = (tag_rdata != '0);
      end
      default: begin
      end
    endcase
  end

  tsfla_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  tsfla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (SLOT_COUNT)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (free_head[IDX_W-1:0]),
    .rdata (link_rdata)
  );

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      free_head <= '0;
      clr_ptr   <= '0;
      chk_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // Drop the response once it is taken, unless a new one is loaded.
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == IDX_W'(SLOT_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_take) begin
            op_idx     <= IDX_W'(req.slot_index);
            op_q       <= req_q;
            scan_ptr   <= LINK_W'(idx_wide);
            chk_vld    <= 1'b0;
            res_slot   <= res_slot_next;
            res_resume <= res_resume_next;
            res_status <= res_status_next;
            state      <= state_next;
          end
        end
        S_ALLOC_RD: begin
          // Link of the head slot is read this cycle.
          state <= S_ALLOC_WR;
        end
        S_ALLOC_WR: begin
          res_slot  <= tsfla_pkg::SLOT_W'(free_head);
          free_head <= link_rdata;
          state     <= S_DONE;
        end
        S_FREE_RD: begin
          state <= S_FREE_WR;
        end
        S_FREE_WR: begin
          if (tag_rdata == '0) begin
            res_status <= tsfla_pkg::ST_ALREADY_FREE;
          end else begin
            free_head <= LINK_W'(op_idx);
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          // Check the slot read last cycle while reading the next one.
          if (chk_vld && cmp_hit) begin
            res_slot   <= tsfla_pkg::SLOT_W'(chk_ptr);
            res_resume <= tsfla_pkg::RESUME_W'(cmp_inc);
            state      <= S_DONE;
          end else if (scan_end) begin
            res_slot   <= '0;
            res_resume <= tsfla_pkg::RESUME_W'(SLOT_COUNT);
            res_status <= tsfla_pkg::ST_NO_MATCH;
            state      <= S_DONE;
          end else begin
            chk_ptr  <= scan_ptr[IDX_W-1:0];
            chk_vld  <= 1'b1;
            scan_ptr <= scan_ptr + 1'b1;
          end
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!rsp_valid || !rsp_stall) begin
            rsp.slot         <= res_slot;
            rsp.resume_index <= res_resume;
            rsp.status       <= res_status;
            rsp_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
